FILE: src/krt_pkg.sv
// Package for the keyed record table: widths, codes, state and cell command types.
// No dependencies; used by krt_cell and keyed_record_table_with_sort.
package krt_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 16;
    localparam int VAL_W        = 24;
    localparam int LIM_W        = 7;
    localparam int OIDX_W       = 6;
    localparam logic [LIM_W-1:0] LIMIT_RST = 7'd16;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_UPDATE = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_SORT_V = 3'd4,
        REQ_SORT_K = 3'd5,
        REQ_READ   = 3'd6,
        REQ_NONE   = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_NOTFD = 2'd2,
        STS_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ADD, ST_SCAN, ST_FIN, ST_SORT, ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        CO_HOLD, CO_LOAD, CO_SHIFT, CO_SORT, CO_DEL, CO_WVAL, CO_WREC
    } t_cell_op;

    // position fields are wide enough for any CAPACITY up to 64
    typedef struct packed {
        t_cell_op           op;
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   val;
        logic [LIM_W-1:0]   pos;
        logic [LIM_W-1:0]   count;
        logic               by_value;
        logic               phase;
    } t_cell_cmd;
endpackage

FILE: src/krt_cell.sv
// One table cell: a stored record plus a shadow record for shifting results out.
// Depends on krt_pkg.
module krt_cell import krt_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [KEY_W-1:0] i_up_key,
    input  logic [VAL_W-1:0] i_up_val,
    input  logic [KEY_W-1:0] i_dn_key,
    input  logic [VAL_W-1:0] i_dn_val,
    input  logic [KEY_W-1:0] i_up_skey,
    input  logic [VAL_W-1:0] i_up_sval,
    input  logic             i_up_shit,
    output logic [KEY_W-1:0] o_key,
    output logic [VAL_W-1:0] o_val,
    output logic [KEY_W-1:0] o_skey,
    output logic [VAL_W-1:0] o_sval,
    output logic             o_shit
);
    localparam logic [LIM_W-1:0] I_POS  = LIM_W'(IDX);
    localparam logic [LIM_W-1:0] I_NEXT = LIM_W'(IDX + 1);
    localparam logic             LO_PH  = (IDX % 2) == 1;
    localparam logic             HAS_DN = IDX > 0;

    logic [KEY_W-1:0] r_key, n_key, r_skey, n_skey;
    logic [VAL_W-1:0] r_val, n_val, r_sval, n_sval;
    logic             r_shit, n_shit;
    logic             w_lo, w_hi, w_ooo_up, w_ooo_dn;

    always_comb begin
        w_ooo_up = i_cmd.by_value ? (r_val < i_up_val) : (r_key > i_up_key);
        w_ooo_dn = i_cmd.by_value ? (i_dn_val < r_val) : (i_dn_key > r_key);
        w_lo     = (i_cmd.phase == LO_PH) && (I_NEXT < i_cmd.count);
        w_hi     = HAS_DN && (i_cmd.phase == !LO_PH) && (I_POS < i_cmd.count);
        n_key  = r_key;
        n_val  = r_val;
        n_skey = r_skey;
        n_sval = r_sval;
        n_shit = r_shit;
        case (i_cmd.op)
            CO_LOAD: begin
                n_skey = r_key;
                n_sval = r_val;
                n_shit = (r_key == i_cmd.key);
            end
            CO_SHIFT: begin
                n_skey = i_up_skey;
                n_sval = i_up_sval;
                n_shit = i_up_shit;
            end
            CO_SORT: begin
                if (w_lo && w_ooo_up) begin
                    n_key = i_up_key;
                    n_val = i_up_val;
                end else if (w_hi && w_ooo_dn) begin
                    n_key = i_dn_key;
                    n_val = i_dn_val;
                end
            end
            CO_DEL: begin
                if (I_POS >= i_cmd.pos) begin
                    n_key = i_up_key;
                    n_val = i_up_val;
                end
            end
            CO_WVAL: begin
                if (I_POS == i_cmd.pos) n_val = i_cmd.val;
            end
            CO_WREC: begin
                if (I_POS == i_cmd.pos) begin
                    n_key = i_cmd.key;
                    n_val = i_cmd.val;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_val  <= n_val;
        r_skey <= n_skey;
        r_sval <= n_sval;
        r_shit <= n_shit;
    end

    assign o_key  = r_key;
    assign o_val  = r_val;
    assign o_skey = r_skey;
    assign o_sval = r_sval;
    assign o_shit = r_shit;
endmodule

FILE: src/keyed_record_table_with_sort.sv
// Top level of the keyed record table: request sequencer, output register and cell row.
// Depends on krt_pkg and krt_cell.
// A packed table of up to CAPACITY records held in a row of cells. Add writes the new
// record behind the last one. Update, delete and search shift a shadow copy of the row
// past cell 0 until a match reaches cell 0 or the row is exhausted. Sorts run count
// odd-even transposition phases across the row, then emit one record a cycle while the
// output register is not stalled. Read all emits the shadow row in the same way.
// A new request is taken only when the sequencer is idle; a finished result may still
// wait in the output register.
module keyed_record_table_with_sort import krt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [47:0]      s_axis_tdata,  // req_type[2:0], rec_key[18:3], rec_value[42:19]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // status[1:0], entry_index[7:2], out_key[23:8],
                                            // out_value[47:24]
    output logic             m_axis_tlast,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_wdata
);
    localparam logic [LIM_W-1:0] CAP_L = LIM_W'(CAPACITY);

    t_state           r_state, n_state;
    t_req             r_req;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [LIM_W-1:0] r_idx, n_idx, r_count, n_count, r_limit;
    logic             r_ov, n_ov;
    logic [47:0]      r_odata, n_odata;
    logic             r_olast, n_olast;

    t_cell_cmd        w_cmd;
    logic             w_acc, w_can, w_push, w_full;
    t_status          w_sts;
    logic [LIM_W-1:0] w_oidx;
    logic [KEY_W-1:0] w_okey;
    logic [VAL_W-1:0] w_oval;
    logic             w_olast;
    t_req             w_in_req;

    logic [KEY_W-1:0] w_key  [CAPACITY];
    logic [VAL_W-1:0] w_val  [CAPACITY];
    logic [KEY_W-1:0] w_skey [CAPACITY];
    logic [VAL_W-1:0] w_sval [CAPACITY];
    logic             w_shit [CAPACITY];

    assign w_in_req      = t_req'(s_axis_tdata[2:0]);
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_can         = !r_ov || m_axis_tready;
    assign w_full        = (r_count >= r_limit) || (r_count >= CAP_L);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (w_in_req)
                        REQ_ADD:                             n_state = ST_ADD;
                        REQ_UPDATE, REQ_DELETE, REQ_SEARCH:  n_state = ST_SCAN;
                        REQ_SORT_V, REQ_SORT_K:              n_state = ST_SORT;
                        REQ_READ:                            n_state = ST_EMIT;
                        default:                             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:  if (w_can) n_state = ST_IDLE;
            ST_SCAN: if (r_idx == r_count || w_shit[0]) n_state = ST_FIN;
            ST_FIN:  if (w_can) n_state = ST_IDLE;
            ST_SORT: if (r_idx == r_count) n_state = ST_EMIT;
            ST_EMIT: if (w_can && (r_count == '0 || r_idx + 1'b1 == r_count)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and cell commands
    always_comb begin
        w_cmd          = '0;
        w_cmd.op       = CO_HOLD;
        w_cmd.key      = r_key;
        w_cmd.val      = r_val;
        w_cmd.pos      = r_idx;
        w_cmd.count    = r_count;
        w_cmd.by_value = (r_req == REQ_SORT_V);
        w_cmd.phase    = r_idx[0];
        n_idx   = r_idx;
        n_count = r_count;
        w_push  = 1'b0;
        w_sts   = STS_OK;
        w_oidx  = '0;
        w_okey  = '0;
        w_oval  = '0;
        w_olast = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    w_cmd.op  = CO_LOAD;
                    w_cmd.key = s_axis_tdata[18:3];
                    n_idx     = '0;
                end
            end
            ST_ADD: begin
                if (w_can) begin
                    w_push = 1'b1;
                    if (w_full) begin
                        w_sts = STS_FULL;
                    end else begin
                        w_cmd.op  = CO_WREC;
                        w_cmd.pos = r_count;
                        w_oidx    = r_count;
                        w_okey    = r_key;
                        w_oval    = r_val;
                        n_count   = r_count + 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (!(r_idx == r_count || w_shit[0])) begin
                    w_cmd.op = CO_SHIFT;
                    n_idx    = r_idx + 1'b1;
                end
            end
            ST_FIN: begin
                if (w_can) begin
                    w_push = 1'b1;
                    if (r_idx == r_count) begin
                        w_sts = STS_NOTFD;
                    end else begin
                        w_oidx = r_idx;
                        w_okey = w_skey[0];
                        w_oval = w_sval[0];
                        if (r_req == REQ_UPDATE) begin
                            w_cmd.op = CO_WVAL;
                            w_oval   = r_val;
                        end else if (r_req == REQ_DELETE) begin
                            w_cmd.op = CO_DEL;
                            n_count  = r_count - 1'b1;
                        end
                    end
                end
            end
            ST_SORT: begin
                if (r_idx == r_count) begin
                    w_cmd.op = CO_LOAD;
                    n_idx    = '0;
                end else begin
                    w_cmd.op = CO_SORT;
                    n_idx    = r_idx + 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_can) begin
                    w_push = 1'b1;
                    if (r_count == '0) begin
                        w_sts = STS_EMPTY;
                    end else begin
                        w_oidx   = r_idx;
                        w_okey   = w_skey[0];
                        w_oval   = w_sval[0];
                        w_olast  = (r_idx + 1'b1 == r_count);
                        w_cmd.op = CO_SHIFT;
                        n_idx    = r_idx + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        n_ov    = w_push ? 1'b1 : (m_axis_tready ? 1'b0 : r_ov);
        n_odata = w_push ? {w_oval, w_okey, OIDX_W'(w_oidx), w_sts} : r_odata;
        n_olast = w_push ? w_olast : r_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_limit <= LIMIT_RST;
            r_ov    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            r_idx   <= n_idx;
            if (i_cfg_we) r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req <= w_in_req;
            r_key <= s_axis_tdata[18:3];
            r_val <= s_axis_tdata[42:19];
        end
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0] w_uk, w_dk, w_usk;
        logic [VAL_W-1:0] w_uv, w_dv, w_usv;
        logic             w_ush;
        if (g == CAPACITY - 1) begin : g_top
            assign w_uk  = '0;
            assign w_uv  = '0;
            assign w_usk = '0;
            assign w_usv = '0;
            assign w_ush = 1'b0;
        end else begin : g_mid
            assign w_uk  = w_key[g+1];
            assign w_uv  = w_val[g+1];
            assign w_usk = w_skey[g+1];
            assign w_usv = w_sval[g+1];
            assign w_ush = w_shit[g+1];
        end
        if (g == 0) begin : g_bot
            assign w_dk = '0;
            assign w_dv = '0;
        end else begin : g_up
            assign w_dk = w_key[g-1];
            assign w_dv = w_val[g-1];
        end
        krt_cell #(.IDX(g)) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (w_cmd),
            .i_up_key  (w_uk),
            .i_up_val  (w_uv),
            .i_dn_key  (w_dk),
            .i_dn_val  (w_dv),
            .i_up_skey (w_usk),
            .i_up_sval (w_usv),
            .i_up_shit (w_ush),
            .o_key     (w_key[g]),
            .o_val     (w_val[g]),
            .o_skey    (w_skey[g]),
            .o_sval    (w_sval[g]),
            .o_shit    (w_shit[g])
        );
    end
endmodule
